// ----- hdl/atpt_pkg.sv -----
// Shared types and constants for the address/tag pair table.
// Holds the operation codes, the transfer structs and the control command bundle.
// No dependencies.
`default_nettype none

package atpt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned KEY_W        = 16;
  localparam int unsigned TAG_W        = 16;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_INSERT    = 3'd0;
  localparam op_t OP_REMOVE    = 3'd1;
  localparam op_t OP_FIND_KEY  = 3'd2;
  localparam op_t OP_FIND_PAIR = 3'd3;
  localparam op_t OP_CLEAR     = 3'd4;

  typedef struct packed {
    op_t              operation;
    logic [KEY_W-1:0] node_address;
    logic [TAG_W-1:0] tag_value;
  } atpt_in_t;

  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] found_tag;
    logic             dropped_full;
  } atpt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } atpt_cmd_t;

endpackage : atpt_pkg

`default_nettype wire

// ----- hdl/atpt_ctrl.sv -----
// Controller for the address/tag pair table: a two-state machine that
// sequences the compare cycle and the write-back cycle. Depends on atpt_pkg.
`default_nettype none

module atpt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output atpt_pkg::atpt_cmd_t     cmd
);
  import atpt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_COMMIT = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r == ST_COMMIT);

endmodule : atpt_ctrl

`default_nettype wire

// ----- hdl/atpt_datapath.sv -----
// Datapath for the address/tag pair table: the key, tag and valid stores,
// the per-entry key compare, the write-back logic and the result register.
// Depends on atpt_pkg.
`default_nettype none

module atpt_datapath #(
  parameter int unsigned CAPACITY = atpt_pkg::CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  atpt_pkg::atpt_cmd_t      cmd,
  input  atpt_pkg::atpt_in_t       in_item,
  output logic                     out_valid,
  output atpt_pkg::atpt_out_t      out_item
);
  import atpt_pkg::*;

  logic [KEY_W-1:0]    key_store_r [CAPACITY];
  logic [TAG_W-1:0]    tag_store_r [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [CAPACITY-1:0] valid_nxt;

  atpt_in_t            item_r;
  logic [CAPACITY-1:0] match_r, match_nxt;
  logic [CAPACITY-1:0] free_r, free_nxt;

  logic [CAPACITY-1:0] key_wr_en;
  logic [CAPACITY-1:0] tag_wr_en;
  logic [TAG_W-1:0]    sel_tag;
  logic                any_match;
  logic                any_free;

  atpt_out_t           out_r, out_nxt;
  logic                out_valid_r;

  // Compare against the incoming key. Keys are unique, so the match vector
  // is at most one-hot. The lowest free entry is isolated as a one-hot mask.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = valid_r[i] && (key_store_r[i] == in_item.node_address);
    end
    free_nxt = ~valid_r & (valid_r + {{(CAPACITY-1){1'b0}}, 1'b1});
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r  <= in_item;
      match_r <= match_nxt;
      free_r  <= free_nxt;
    end
  end

  // Tag of the matched entry, selected through the one-hot match vector.
  always_comb begin
    sel_tag = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_tag = sel_tag | (tag_store_r[i] & {TAG_W{match_r[i]}});
    end
  end

  assign any_match = |match_r;
  assign any_free  = |free_r;

  always_comb begin
    valid_nxt = valid_r;
    key_wr_en = '0;
    tag_wr_en = '0;
    out_nxt   = '0;
    unique case (item_r.operation)
      OP_INSERT: begin
        // The all-zero pair marks an empty table and is never stored.
        if ((item_r.node_address != '0) || (item_r.tag_value != '0)) begin
          if (any_match) begin
            tag_wr_en         = match_r;
            out_nxt.hit       = 1'b1;
            out_nxt.found_tag = item_r.tag_value;
          end else if (any_free) begin
            key_wr_en = free_r;
            tag_wr_en = free_r;
            valid_nxt = valid_r | free_r;
          end else begin
            out_nxt.dropped_full = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (any_match) begin
          out_nxt.hit       = 1'b1;
          out_nxt.found_tag = sel_tag;
          valid_nxt         = valid_r & ~match_r;
        end
      end
      OP_FIND_KEY: begin
        if (any_match) begin
          out_nxt.hit       = 1'b1;
          out_nxt.found_tag = sel_tag;
        end
      end
      OP_FIND_PAIR: begin
        if (any_match && (sel_tag == item_r.tag_value)) begin
          out_nxt.hit       = 1'b1;
          out_nxt.found_tag = item_r.tag_value;
        end
      end
      OP_CLEAR: begin
        valid_nxt = '0;
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.commit && key_wr_en[i]) begin
        key_store_r[i] <= item_r.node_address;
      end
      if (cmd.commit && tag_wr_en[i]) begin
        tag_store_r[i] <= item_r.tag_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule : atpt_datapath

`default_nettype wire

// ----- hdl/address_tag_pair_table.sv -----
// Top level of the address/tag pair table: controller plus datapath.
// Depends on atpt_pkg, atpt_ctrl and atpt_datapath.
//
// Each command has a compare step and a write-back step: in the cycle
// in which start is seen with busy low, the key is compared against every
// valid entry at once and the match and lowest-free masks are registered;
// in the next cycle (busy high) the stores are written back and the result
// is registered. out_valid is then high for exactly one cycle, during which
// a new command may already be accepted; none is taken while busy. The
// receiver cannot stall, so results must be taken when out_valid is high.
`default_nettype none

module address_tag_pair_table #(
  parameter int unsigned CAPACITY = atpt_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  atpt_pkg::atpt_in_t      in_item,
  output logic                    out_valid,
  output atpt_pkg::atpt_out_t     out_item
);
  import atpt_pkg::*;

  atpt_cmd_t cmd;

  atpt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  atpt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule : address_tag_pair_table

`default_nettype wire

// ----- hdl/atpt_checker.sv -----
// Port-level checker for the address/tag pair table, bound to the top level.
// Depends on atpt_pkg.
`default_nettype none

module atpt_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic               out_valid,
  input  atpt_pkg::atpt_out_t     out_item
);
  import atpt_pkg::*;

  // An accepted transfer makes the block busy for exactly one cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not follow an accepted transfer");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("busy lasted too long or the result strobe was missing");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  a_drop_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.dropped_full) |->
      (!out_item.hit && (out_item.found_tag == '0)))
    else $error("dropped insert reported a hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.hit) |-> (out_item.found_tag == '0))
    else $error("miss carried a nonzero tag");

endmodule : atpt_checker

bind address_tag_pair_table atpt_checker u_atpt_checker (.*);

`default_nettype wire
